[src/fdsu_pkg.sv]
// fdsu_pkg: shared types, constants and decode tables of the forth data stack unit
`timescale 1ns / 1ps
package fdsu_pkg;

	// sizes of the stack
	localparam int STACK_DEPTH = 64;
	localparam int CELL_WIDTH  = 16;
	localparam int TOP_CELLS   = 4;
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int CMP_W       = (CELL_WIDTH > DEPTH_W) ? CELL_WIDTH : DEPTH_W;

	// fixed field widths of the channels
	localparam int OP_W        = 4;
	localparam int VALUE_W     = 16;
	localparam int STATUS_W    = 2;
	localparam int DEPTH_OUT_W = 7;

	typedef logic [CELL_WIDTH-1:0]  cell_t;
	typedef logic [DEPTH_W-1:0]     depth_t;
	typedef logic [DEPTH_W:0]       dwide_t;
	typedef logic [CMP_W-1:0]       cmp_t;
	typedef logic [VALUE_W-1:0]     value_t;
	typedef logic [DEPTH_OUT_W-1:0] depth_out_t;

	localparam dwide_t DEPTH_LIM = dwide_t'(STACK_DEPTH);
	localparam cmp_t   PTR_LIM   = cmp_t'(STACK_DEPTH);

	typedef enum logic [OP_W-1:0] {
		OP_PUSH     = 4'd0,
		OP_POP      = 4'd1,
		OP_DUP      = 4'd2,
		OP_QDUP     = 4'd3,
		OP_DROP     = 4'd4,
		OP_OVER     = 4'd5,
		OP_ROT      = 4'd6,
		OP_SWAP     = 4'd7,
		OP_MINUSROT = 4'd8,
		OP_PRESS    = 4'd9,
		OP_2SWAP    = 4'd10,
		OP_2DUP     = 4'd11,
		OP_2DROP    = 4'd12,
		OP_2OVER    = 4'd13,
		OP_SPFETCH  = 4'd14,
		OP_SPSTORE  = 4'd15
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_UNDER  = 2'd1,
		ST_OVER   = 2'd2,
		ST_BADPTR = 2'd3
	} status_t;

	// ring movement of the cell row: up makes the stack deeper
	typedef enum logic [2:0] {
		SH_HOLD,
		SH_UP1,
		SH_UP2,
		SH_DN1,
		SH_DN2
	} shift_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_ROT
	} fsm_t;

	// control broadcast to the row, with overrides for the top cells
	typedef struct packed {
		shift_t                    sh;
		logic  [TOP_CELLS-1:0]     wr;
		cell_t [TOP_CELLS-1:0]     wdata;
	} chain_ctl_t;

	// control seen by one cell
	typedef struct packed {
		shift_t sh;
		logic   wr;
		cell_t  wdata;
	} cell_ctl_t;

	// number of cells an operation needs on the stack
	function automatic logic [2:0] need_of(op_t op);
		logic [2:0] n;
		unique case (op)
			OP_PUSH, OP_SPFETCH:                         n = 3'd0;
			OP_POP, OP_DUP, OP_QDUP, OP_DROP, OP_SPSTORE: n = 3'd1;
			OP_OVER, OP_SWAP, OP_PRESS, OP_2DUP, OP_2DROP: n = 3'd2;
			OP_ROT, OP_MINUSROT:                         n = 3'd3;
			OP_2SWAP, OP_2OVER:                          n = 3'd4;
			default:                                     n = 3'd0;
		endcase
		return n;
	endfunction

	// size of the depth change (sp store handled apart)
	function automatic logic [1:0] grow_mag_of(op_t op);
		logic [1:0] m;
		unique case (op)
			OP_PUSH, OP_POP, OP_DUP, OP_QDUP, OP_DROP,
			OP_OVER, OP_PRESS, OP_SPFETCH:             m = 2'd1;
			OP_2DUP, OP_2DROP, OP_2OVER:               m = 2'd2;
			default:                                   m = 2'd0;
		endcase
		return m;
	endfunction

	// depth change is a shrink
	function automatic logic grow_dn_of(op_t op);
		return (op == OP_POP) || (op == OP_DROP) || (op == OP_PRESS) || (op == OP_2DROP);
	endfunction

endpackage

[src/fdsu_op_if.sv]
// fdsu_op_if: request channel carrying one stack operation
`timescale 1ns / 1ps
interface fdsu_op_if;
	logic                                  valid;
	logic                                  ready;
	logic [fdsu_pkg::OP_W-1:0]             operation;
	fdsu_pkg::value_t                      push_value;

	modport source (output valid, output operation, output push_value, input ready);
	modport sink   (input valid, input operation, input push_value, output ready);
endinterface

[src/fdsu_res_if.sv]
// fdsu_res_if: result channel carrying top cell, status and depth
`timescale 1ns / 1ps
interface fdsu_res_if;
	logic                           valid;
	logic                           ready;
	fdsu_pkg::value_t               top_value;
	logic [fdsu_pkg::STATUS_W-1:0]  status;
	fdsu_pkg::depth_out_t           depth;

	modport source (output valid, output top_value, output status, output depth, input ready);
	modport sink   (input valid, input top_value, input status, input depth, output ready);
endinterface

[src/fdsu_cell.sv]
// fdsu_cell: one storage cell of the rotating stack row
`timescale 1ns / 1ps
module fdsu_cell (
	input  logic                clk,
	input  fdsu_pkg::cell_ctl_t ctl,
	input  fdsu_pkg::cell_t     shal1,
	input  fdsu_pkg::cell_t     shal2,
	input  fdsu_pkg::cell_t     deep1,
	input  fdsu_pkg::cell_t     deep2,
	output fdsu_pkg::cell_t     val,
	output fdsu_pkg::cell_t     nxt
);

	fdsu_pkg::cell_t val_q;
	fdsu_pkg::cell_t moved;

	// pick the neighbour value for the ring movement
	always_comb begin
		unique case (ctl.sh)
			fdsu_pkg::SH_UP1: moved = shal1;
			fdsu_pkg::SH_UP2: moved = shal2;
			fdsu_pkg::SH_DN1: moved = deep1;
			fdsu_pkg::SH_DN2: moved = deep2;
			default:          moved = val_q;
		endcase
		nxt = ctl.wr ? ctl.wdata : moved;
	end

	// cell storage
	always_ff @(posedge clk) begin
		val_q <= nxt;
	end

	assign val = val_q;

endmodule

[src/fdsu_ctrl.sv]
// fdsu_ctrl: decode, depth tracking, sp store sequencer and result register
`timescale 1ns / 1ps
module fdsu_ctrl (
	input  logic                                         clk,
	input  logic                                         arst_n,
	fdsu_op_if.sink                                      cmd,
	fdsu_res_if.source                                   rsp,
	input  fdsu_pkg::cell_t [fdsu_pkg::TOP_CELLS-1:0]    top4,
	input  fdsu_pkg::cell_t                              top_nxt,
	output fdsu_pkg::chain_ctl_t                         chain
);

	fdsu_pkg::fsm_t    state_q, state_nxt;
	fdsu_pkg::depth_t  depth_q, depth_nxt;
	fdsu_pkg::depth_t  target_q;
	logic              rsp_valid_q;
	fdsu_pkg::value_t  rsp_top_q;
	fdsu_pkg::status_t rsp_status_q;
	fdsu_pkg::depth_t  rsp_depth_q;

	fdsu_pkg::op_t     op;
	fdsu_pkg::cell_t   pv, a, b, c, d;
	logic              go;
	logic [1:0]        grow_mag;
	logic              grow_dn;
	fdsu_pkg::status_t status;
	logic              sp_ok;
	logic              rot_up;
	fdsu_pkg::depth_t  rot_dist;
	logic              load;
	fdsu_pkg::cell_t   res_top;
	fdsu_pkg::status_t res_status;

	assign op = fdsu_pkg::op_t'(cmd.operation);
	assign pv = fdsu_pkg::cell_t'(cmd.push_value);
	assign a  = top4[0];
	assign b  = top4[1];
	assign c  = top4[2];
	assign d  = top4[3];

	assign cmd.ready = (state_q == fdsu_pkg::FSM_IDLE) && (!rsp_valid_q || rsp.ready);
	assign go        = cmd.valid && cmd.ready;

	// checks on the incoming request
	always_comb begin
		grow_mag = fdsu_pkg::grow_mag_of(op);
		grow_dn  = fdsu_pkg::grow_dn_of(op);
		if (op == fdsu_pkg::OP_QDUP && depth_q != '0 && a == '0) begin
			grow_mag = 2'd0;
		end
		priority if (depth_q < fdsu_pkg::depth_t'(fdsu_pkg::need_of(op))) begin
			status = fdsu_pkg::ST_UNDER;
		end else if (!grow_dn && grow_mag != 2'd0 &&
				({1'b0, depth_q} + fdsu_pkg::dwide_t'(grow_mag)) > fdsu_pkg::DEPTH_LIM) begin
			status = fdsu_pkg::ST_OVER;
		end else if (op == fdsu_pkg::OP_SPSTORE && fdsu_pkg::cmp_t'(a) > fdsu_pkg::PTR_LIM) begin
			status = fdsu_pkg::ST_BADPTR;
		end else begin
			status = fdsu_pkg::ST_OK;
		end
		sp_ok = (op == fdsu_pkg::OP_SPSTORE) && (status == fdsu_pkg::ST_OK);
		// distance still to rotate for sp store
		rot_up   = target_q > depth_q;
		rot_dist = rot_up ? (target_q - depth_q) : (depth_q - target_q);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			fdsu_pkg::FSM_IDLE: begin
				if (go && sp_ok) begin
					state_nxt = fdsu_pkg::FSM_ROT;
				end
			end
			fdsu_pkg::FSM_ROT: begin
				if (rot_dist == '0) begin
					state_nxt = fdsu_pkg::FSM_IDLE;
				end
			end
			default: state_nxt = fdsu_pkg::FSM_IDLE;
		endcase
	end

	// row control, new depth and result
	always_comb begin
		chain.sh    = fdsu_pkg::SH_HOLD;
		chain.wr    = '0;
		chain.wdata = '0;
		depth_nxt   = depth_q;
		load        = 1'b0;
		res_top     = '0;
		res_status  = fdsu_pkg::ST_OK;
		unique case (state_q)
			fdsu_pkg::FSM_IDLE: begin
				if (go && status != fdsu_pkg::ST_OK) begin
					load       = 1'b1;
					res_status = status;
					res_top    = (depth_q == '0) ? '0 : a;
				end else if (go && !sp_ok) begin
					load = 1'b1;
					if (grow_dn) begin
						depth_nxt = depth_q - fdsu_pkg::depth_t'(grow_mag);
					end else begin
						depth_nxt = depth_q + fdsu_pkg::depth_t'(grow_mag);
					end
					priority case ({grow_dn, grow_mag})
						3'b001:  chain.sh = fdsu_pkg::SH_UP1;
						3'b010:  chain.sh = fdsu_pkg::SH_UP2;
						3'b101:  chain.sh = fdsu_pkg::SH_DN1;
						3'b110:  chain.sh = fdsu_pkg::SH_DN2;
						default: chain.sh = fdsu_pkg::SH_HOLD;
					endcase
					// overrides of the top cells, new frame
					unique case (op)
						fdsu_pkg::OP_PUSH: begin
							chain.wr[0] = 1'b1; chain.wdata[0] = pv;
						end
						fdsu_pkg::OP_DUP, fdsu_pkg::OP_PRESS: begin
							chain.wr[0] = 1'b1; chain.wdata[0] = a;
						end
						fdsu_pkg::OP_QDUP: begin
							chain.wr[0] = grow_mag != 2'd0; chain.wdata[0] = a;
						end
						fdsu_pkg::OP_OVER: begin
							chain.wr[0] = 1'b1; chain.wdata[0] = b;
						end
						fdsu_pkg::OP_ROT: begin
							chain.wr[2:0] = 3'b111;
							chain.wdata[2] = b; chain.wdata[1] = a; chain.wdata[0] = c;
						end
						fdsu_pkg::OP_SWAP: begin
							chain.wr[1:0] = 2'b11;
							chain.wdata[1] = a; chain.wdata[0] = b;
						end
						fdsu_pkg::OP_MINUSROT: begin
							chain.wr[2:0] = 3'b111;
							chain.wdata[2] = a; chain.wdata[1] = c; chain.wdata[0] = b;
						end
						fdsu_pkg::OP_2SWAP: begin
							chain.wr = '1;
							chain.wdata[3] = b; chain.wdata[2] = a;
							chain.wdata[1] = d; chain.wdata[0] = c;
						end
						fdsu_pkg::OP_2DUP: begin
							chain.wr[1:0] = 2'b11;
							chain.wdata[1] = b; chain.wdata[0] = a;
						end
						fdsu_pkg::OP_2OVER: begin
							chain.wr[1:0] = 2'b11;
							chain.wdata[1] = d; chain.wdata[0] = c;
						end
						fdsu_pkg::OP_SPFETCH: begin
							chain.wr[0] = 1'b1; chain.wdata[0] = fdsu_pkg::cell_t'(depth_q);
						end
						default: begin
							chain.wr = '0;
						end
					endcase
					if (op == fdsu_pkg::OP_POP) begin
						res_top = a;
					end else begin
						res_top = (depth_nxt == '0) ? '0 : top_nxt;
					end
				end
			end
			fdsu_pkg::FSM_ROT: begin
				// walk the ring towards the stored depth, at most two cells a cycle
				if (rot_dist == '0) begin
					load    = 1'b1;
					res_top = (depth_q == '0) ? '0 : a;
				end else if (rot_dist == fdsu_pkg::depth_t'(1)) begin
					chain.sh  = rot_up ? fdsu_pkg::SH_UP1 : fdsu_pkg::SH_DN1;
					depth_nxt = rot_up ? depth_q + fdsu_pkg::depth_t'(1)
					                   : depth_q - fdsu_pkg::depth_t'(1);
				end else begin
					chain.sh  = rot_up ? fdsu_pkg::SH_UP2 : fdsu_pkg::SH_DN2;
					depth_nxt = rot_up ? depth_q + fdsu_pkg::depth_t'(2)
					                   : depth_q - fdsu_pkg::depth_t'(2);
				end
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fdsu_pkg::FSM_IDLE;
			depth_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			depth_q <= depth_nxt;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (go && sp_ok) begin
			target_q <= fdsu_pkg::depth_t'(a);
		end
		if (load) begin
			rsp_top_q    <= fdsu_pkg::value_t'(res_top);
			rsp_status_q <= res_status;
			rsp_depth_q  <= depth_nxt;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.top_value = rsp_top_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.depth     = fdsu_pkg::depth_out_t'(rsp_depth_q);

endmodule

[src/forth_data_stack_unit.sv]
// forth_data_stack_unit: top level, ring of stack cells under one controller
//
//   channel  role    payload
//   cmd      sink    operation, push_value
//   rsp      source  top_value, status, depth
//
// One request a cycle for every operation but sp store, while the result register
// is empty or drained; its result sits in the output register the cycle after the
// request is taken. sp store rotates the cell ring at most two places a cycle until
// the top lines up with the new depth.
// Reset clears the depth to zero; cell contents stay unknown until written.
// A new request is taken only when the result register is empty or drained.
`timescale 1ns / 1ps
module forth_data_stack_unit (
	input  logic       clk,
	input  logic       arst_n,
	fdsu_op_if.sink    cmd,
	fdsu_res_if.source rsp
);

	fdsu_pkg::cell_t                           val [fdsu_pkg::STACK_DEPTH];
	fdsu_pkg::cell_t                           nxt [fdsu_pkg::STACK_DEPTH];
	fdsu_pkg::cell_t [fdsu_pkg::TOP_CELLS-1:0] top4;
	fdsu_pkg::chain_ctl_t                      chain;

	// controller
	fdsu_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rsp     (rsp),
		.top4    (top4),
		.top_nxt (nxt[0]),
		.chain   (chain)
	);

	// ring of cells, cell 0 holds the top of stack
	for (genvar k = 0; k < fdsu_pkg::STACK_DEPTH; k++) begin : g_cell
		fdsu_pkg::cell_ctl_t ctl;
		if (k < fdsu_pkg::TOP_CELLS) begin : g_top
			assign ctl.sh    = chain.sh;
			assign ctl.wr    = chain.wr[k];
			assign ctl.wdata = chain.wdata[k];
			assign top4[k]   = val[k];
		end else begin : g_deep
			assign ctl.sh    = chain.sh;
			assign ctl.wr    = 1'b0;
			assign ctl.wdata = '0;
		end
		fdsu_cell u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.shal1 (val[(k + fdsu_pkg::STACK_DEPTH - 1) % fdsu_pkg::STACK_DEPTH]),
			.shal2 (val[(k + fdsu_pkg::STACK_DEPTH - 2) % fdsu_pkg::STACK_DEPTH]),
			.deep1 (val[(k + 1) % fdsu_pkg::STACK_DEPTH]),
			.deep2 (val[(k + 2) % fdsu_pkg::STACK_DEPTH]),
			.val   (val[k]),
			.nxt   (nxt[k])
		);
	end

endmodule

[bench/forth_data_stack_unit_checker.sv]
// forth_data_stack_unit_checker: reply predictor and scoreboard of the forth data stack unit
`timescale 1ns / 1ps
module forth_data_stack_unit_checker
	import fdsu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	fdsu_op_if          cmd,
	fdsu_res_if         rsp,
	output int unsigned errors,
	output int unsigned owed
);

	typedef struct packed {
		value_t     top;
		status_t    st;
		depth_out_t depth;
	} stack_reply_t;

	// shadow of the stack
	cell_t        cell_row [STACK_DEPTH];
	int           cells_held = 0;
	stack_reply_t replies_due [$];
	stack_reply_t want;
	int unsigned  err_tally = 0;

	// cell k places below the top, zero where the stack is too shallow
	function automatic cell_t cell_below(int k);
		return (cells_held > k) ? cell_row[cells_held - 1 - k] : '0;
	endfunction

	function automatic void set_cell_below(int k, cell_t v);
		cell_row[cells_held - 1 - k] = v;
	endfunction

	// cells a request must find on the stack
	function automatic int cells_needed(op_t op);
		case (op)
			OP_PUSH, OP_SPFETCH:                          return 0;
			OP_POP, OP_DUP, OP_QDUP, OP_DROP, OP_SPSTORE: return 1;
			OP_ROT, OP_MINUSROT:                          return 3;
			OP_2SWAP, OP_2OVER:                           return 4;
			default:                                      return 2;
		endcase
	endfunction

	// change of depth a request makes when it succeeds (sp store apart)
	function automatic int cells_added(op_t op);
		case (op)
			OP_PUSH, OP_DUP, OP_QDUP, OP_OVER, OP_SPFETCH: return 1;
			OP_POP, OP_DROP, OP_PRESS:                     return -1;
			OP_2DUP, OP_2OVER:                             return 2;
			OP_2DROP:                                      return -2;
			default:                                       return 0;
		endcase
	endfunction

	// carry out one request on the shadow and give the reply it must produce
	function automatic stack_reply_t apply_stack_op(op_t op, cell_t pv);
		stack_reply_t r;
		int           grow;
		int           old_depth;
		cell_t        a, b, c, d;
		grow = cells_added(op);
		if (op == OP_QDUP && cells_held >= 1 && cell_below(0) == '0)
			grow = 0;
		r.st = ST_OK;
		if (cells_held < cells_needed(op))
			r.st = ST_UNDER;
		else if (grow > 0 && cells_held + grow > STACK_DEPTH)
			r.st = ST_OVER;
		else if (op == OP_SPSTORE && int'(cell_below(0)) > STACK_DEPTH)
			r.st = ST_BADPTR;
		// a refused request leaves everything as it was
		if (r.st != ST_OK) begin
			r.top   = value_t'(cell_below(0));
			r.depth = depth_out_t'(cells_held);
			return r;
		end
		a = cell_below(0);
		b = cell_below(1);
		c = cell_below(2);
		d = cell_below(3);
		case (op)
			OP_PUSH: begin
				cells_held++;
				set_cell_below(0, pv);
			end
			OP_POP, OP_DROP: cells_held--;
			OP_DUP: begin
				cells_held++;
				set_cell_below(0, a);
			end
			OP_QDUP: begin
				if (a != '0) begin
					cells_held++;
					set_cell_below(0, a);
				end
			end
			OP_OVER: begin
				cells_held++;
				set_cell_below(0, b);
			end
			OP_ROT: begin
				set_cell_below(2, b);
				set_cell_below(1, a);
				set_cell_below(0, c);
			end
			OP_SWAP: begin
				set_cell_below(1, a);
				set_cell_below(0, b);
			end
			OP_MINUSROT: begin
				set_cell_below(2, a);
				set_cell_below(1, c);
				set_cell_below(0, b);
			end
			OP_PRESS: begin
				cells_held--;
				set_cell_below(0, a);
			end
			OP_2SWAP: begin
				set_cell_below(3, b);
				set_cell_below(2, a);
				set_cell_below(1, d);
				set_cell_below(0, c);
			end
			OP_2DUP: begin
				cells_held += 2;
				set_cell_below(1, b);
				set_cell_below(0, a);
			end
			OP_2DROP: cells_held -= 2;
			OP_2OVER: begin
				cells_held += 2;
				set_cell_below(1, d);
				set_cell_below(0, c);
			end
			OP_SPFETCH: begin
				old_depth = cells_held;
				cells_held++;
				set_cell_below(0, cell_t'(old_depth));
			end
			OP_SPSTORE: cells_held = int'(a);
		endcase
		// pop reports the cell it took, all others the new top
		r.top   = (op == OP_POP) ? value_t'(a) : value_t'(cell_below(0));
		r.depth = depth_out_t'(cells_held);
		return r;
	endfunction

	// score the reply first, then log the request taken at the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replies_due.delete();
			cells_held = 0;
			foreach (cell_row[i])
				cell_row[i] = '0;
			err_tally = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (replies_due.size() == 0) begin
					$error("reply with none owed: top_value %0h status %0d depth %0d",
						rsp.top_value, rsp.status, rsp.depth);
					err_tally++;
				end else begin
					want = replies_due.pop_front();
					if (rsp.top_value !== want.top) begin
						$error("top_value: expected %0h, got %0h", want.top, rsp.top_value);
						err_tally++;
					end
					if (rsp.status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, rsp.status);
						err_tally++;
					end
					if (rsp.depth !== want.depth) begin
						$error("depth: expected %0d, got %0d", want.depth, rsp.depth);
						err_tally++;
					end
				end
			end
			if (cmd.valid && cmd.ready)
				replies_due.push_back(apply_stack_op(op_t'(cmd.operation), cmd.push_value));
		end
		errors <= err_tally;
		owed   <= replies_due.size();
	end

endmodule

[bench/forth_data_stack_unit_tb.sv]
// forth_data_stack_unit_tb: stimulus, idling and verdict around the forth data stack unit
`timescale 1ns / 1ps
module forth_data_stack_unit_tb;
	import fdsu_pkg::*;

	localparam int unsigned TOTAL_REQUESTS = 1600;
	localparam int unsigned HOLD_CYCLES    = 400;
	localparam int unsigned QUIET_LIMIT    = 4000;
	localparam int unsigned DRAIN_CYCLES   = 64;
	localparam int unsigned HOLD_SPACING   = 700;

	localparam op_t SHRINK_OPS [4]  = '{OP_POP, OP_DROP, OP_PRESS, OP_2DROP};
	localparam op_t SHUFFLE_OPS [9] = '{OP_DUP, OP_QDUP, OP_OVER, OP_ROT, OP_SWAP,
		OP_MINUSROT, OP_2SWAP, OP_2DUP, OP_2OVER};

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	int unsigned errors;
	int unsigned owed;
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned requests_sent  = 0;
	int unsigned quiet_cycles   = 0;
	int unsigned next_hold_at;
	bit          hold_off_req   = 1'b0;

	fdsu_op_if  cmd_ch ();
	fdsu_res_if rsp_ch ();

	forth_data_stack_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	forth_data_stack_unit_checker chk (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch),
		.errors (errors),
		.owed   (owed)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// no request moving for too long means the block is stuck
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// reply side: random stalls, or a long hold-off on request
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// idling phases: none, sender idle, receiver stalling, both a little
	task automatic set_idling(int unsigned phase);
		case (phase)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
			default: begin send_idle_pct = 7; recv_stall_pct = 7; end
		endcase
	endtask

	// cell values weighted towards the extremes and small depths
	function automatic value_t pick_value();
		case ($urandom_range(5))
			0:       return '0;
			1:       return '1;
			2, 3:    return value_t'($urandom_range(STACK_DEPTH + 2));
			default: return value_t'($urandom);
		endcase
	endfunction

	// offer one request and wait until the block takes it
	task automatic send_op(op_t op, value_t v);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.operation  <= op;
		cmd_ch.push_value <= v;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		requests_sent++;
	endtask

	initial begin
		cmd_ch.valid      <= 1'b0;
		cmd_ch.operation  <= OP_PUSH;
		cmd_ch.push_value <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty stack, zero handling and every operation on a shallow stack
		set_idling(0);
		send_op(OP_POP, '1);
		send_op(OP_2OVER, '0);
		send_op(OP_SPSTORE, '0);
		send_op(OP_2DROP, '0);
		send_op(OP_SPFETCH, '0);
		send_op(OP_QDUP, '0);
		send_op(OP_SPSTORE, '0);
		send_op(OP_PUSH, 16'hFFFF);
		send_op(OP_PUSH, 16'h0000);
		send_op(OP_PUSH, 16'h0001);
		send_op(OP_PUSH, 16'h8000);
		send_op(OP_QDUP, '0);
		send_op(OP_DROP, '0);
		send_op(OP_DUP, '0);
		send_op(OP_OVER, '0);
		send_op(OP_ROT, '0);
		send_op(OP_SWAP, '0);
		send_op(OP_MINUSROT, '0);
		send_op(OP_PRESS, '0);
		send_op(OP_2SWAP, '0);
		send_op(OP_2DUP, '0);
		send_op(OP_2DROP, '0);
		send_op(OP_2OVER, '0);
		send_op(OP_SPFETCH, '0);
		send_op(OP_SPSTORE, '0);

		// fill every cell, running into overflow at the end
		set_idling(3);
		repeat (STACK_DEPTH + 2)
			send_op(OP_PUSH, pick_value());

		// overflow of each growing operation on a full stack
		send_op(OP_DUP, '0);
		send_op(OP_OVER, '0);
		send_op(OP_2DUP, '0);
		send_op(OP_2OVER, '0);
		send_op(OP_SPFETCH, '0);
		send_op(OP_DROP, '0);
		send_op(OP_PUSH, '0);
		send_op(OP_QDUP, '0);
		send_op(OP_DROP, '0);
		send_op(OP_PUSH, value_t'(STACK_DEPTH));
		send_op(OP_QDUP, '0);
		send_op(OP_SPSTORE, '0);
		// sp store just past capacity and far beyond it
		send_op(OP_DROP, '0);
		send_op(OP_PUSH, value_t'(STACK_DEPTH + 1));
		send_op(OP_SPSTORE, '0);
		send_op(OP_DROP, '0);
		send_op(OP_PUSH, '1);
		send_op(OP_SPSTORE, '0);
		send_op(OP_DROP, '0);
		send_op(OP_PUSH, '0);
		send_op(OP_SPSTORE, '0);
		send_op(OP_SPSTORE, '0);
		send_op(OP_ROT, '0);

		// random sequences, with the reply side held off now and then
		next_hold_at = requests_sent;
		while (requests_sent < TOTAL_REQUESTS) begin
			set_idling((requests_sent / 150) % 4);
			if (requests_sent >= next_hold_at) begin
				set_idling(0);
				hold_off_req = 1'b1;
				next_hold_at += HOLD_SPACING;
			end
			case ($urandom_range(9))
				0, 1: send_op(op_t'($urandom_range(15)), value_t'($urandom));
				2: repeat ($urandom_range(1, 70)) send_op(OP_PUSH, pick_value());
				3: repeat ($urandom_range(1, 70))
					send_op(SHRINK_OPS[$urandom_range(3)], value_t'($urandom));
				4, 5: begin
					send_op(OP_PUSH, value_t'($urandom_range(STACK_DEPTH + 2)));
					send_op(OP_SPSTORE, value_t'($urandom));
				end
				6: begin
					send_op(OP_SPFETCH, value_t'($urandom));
					repeat ($urandom_range(0, 4))
						send_op(SHUFFLE_OPS[$urandom_range(8)], value_t'($urandom));
					send_op(OP_SPSTORE, value_t'($urandom));
				end
				default: repeat ($urandom_range(1, 12))
					send_op(SHUFFLE_OPS[$urandom_range(8)], pick_value());
			endcase
		end
		cmd_ch.valid <= 1'b0;

		// drain the outstanding replies, then allow for stragglers
		@(posedge clk);
		while (owed != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && owed == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
